@@ rtl/wst_pkg.sv @@
// Shared widths, types and register codes for the weighted spread table.
package wst_pkg;

  // Store and field geometry
  localparam int MaxServers = 16;
  localparam int SelW       = 4;   // server index width
  localparam int WgtW       = 4;   // per-server weight width
  localparam int SlotW      = 8;   // table slot width
  localparam int CntW       = 5;   // server count, holds MaxServers itself
  localparam int SumW       = 8;   // total weight, at most 16 * 15
  localparam int StepW      = 3;   // remainder step counter, SlotW steps
  localparam int RoundW     = 4;   // interleave round counter
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 5;

  // Request codes
  localparam logic ReqSetWeight = 1'b0;
  localparam logic ReqLookup    = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSpreadMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgServersInUse = 2'd1;

  // Spread mode codes
  localparam logic ModeGrouped     = 1'b0;
  localparam logic ModeInterleaved = 1'b1;

  // Last interleave round that can hold a server (weights reach 15)
  localparam logic [RoundW-1:0] LastRound = 4'd14;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_DONE = 5'b10000
  } wst_state_t;

endpackage

@@ rtl/wst_if.sv @@
// Valid/ready channel interfaces for requests, results and configuration.
interface wst_in_if import wst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SelW-1:0]   server_sel;
  logic [WgtW-1:0]   new_weight;
  logic [SlotW-1:0]  slot;

  modport source (output valid, req_type, server_sel, new_weight, slot, input ready);
  modport sink   (input valid, req_type, server_sel, new_weight, slot, output ready);
endinterface

interface wst_out_if import wst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SelW-1:0]  owner;
  logic             error;

  modport source (output valid, owner, error, input ready);
  modport sink   (input valid, owner, error, output ready);
endinterface

interface wst_cfg_if import wst_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CfgIdxW-1:0]   index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/weighted_spread_table.sv @@
// Weighted spread table top level: weight store, lookup sequencer and output register.
//
// The block keeps a 4-bit weight for each of 16 servers and resolves a hash
// table slot to its owning server. A weight write passes through the done
// state into the output register. A lookup walks the weight store once to
// total the weights, derives slot mod total with a restoring remainder unit
// (one bit per cycle), then walks the weight store again one entry per
// cycle. In grouped mode that second walk stops at the owner or after the
// servers in use; in interleaved mode it runs round by round, up to the last
// round. A lookup that finds a zero total skips the remainder and the second
// walk and returns after the first walk. One word is processed at a time;
// in_ch.ready is high only while the sequencer is idle. The result stays in
// an output register until taken. Configuration is accepted every cycle.
module weighted_spread_table import wst_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  wst_in_if.sink       in_ch,
  wst_out_if.source    out_ch,
  wst_cfg_if.sink      cfg_ch
);

  wst_state_t         state_r, state_nxt;
  logic [WgtW-1:0]    weights_r [MaxServers];
  logic               spread_mode_r;
  logic [CntW-1:0]    servers_in_use_r;

  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic [SumW-1:0]    acc_r, acc_nxt;
  logic [SumW-1:0]    total_r, total_nxt;
  logic [SumW-1:0]    rem_r, rem_nxt;
  logic [SlotW-1:0]   slot_r, slot_nxt;
  logic [StepW-1:0]   step_r, step_nxt;
  logic [RoundW-1:0]  round_r, round_nxt;
  logic [SelW-1:0]    rank_r, rank_nxt;
  logic [SelW-1:0]    res_owner_r, res_owner_nxt;
  logic               res_err_r, res_err_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [SelW-1:0]    out_owner_r, out_owner_nxt;
  logic               out_error_r, out_error_nxt;

  logic [CntW-1:0]    n_active;
  logic               in_fire;
  logic               wr_en;
  logic [WgtW-1:0]    cur_w;
  logic [SumW:0]      acc_plus_w;
  logic [SumW:0]      rem_sh;
  logic [SumW:0]      rem_diff;

  // Saturate the server count to the store depth
  assign n_active = (servers_in_use_r > CntW'(MaxServers)) ? CntW'(MaxServers)
                                                            : servers_in_use_r;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid = out_valid_r;
  assign out_ch.owner = out_owner_r;
  assign out_ch.error = out_error_r;

  // Shared datapath: current weight, running sum and remainder step
  assign cur_w      = weights_r[cnt_r[SelW-1:0]];
  assign acc_plus_w = {1'b0, acc_r} + {{(SumW+1-WgtW){1'b0}}, cur_w};
  assign rem_sh     = {rem_r, slot_r[SlotW-1]};
  assign rem_diff   = rem_sh - {1'b0, total_r};

  assign wr_en = in_fire && (in_ch.req_type == ReqSetWeight) &&
                 ({1'b0, in_ch.server_sel} < n_active);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    rem_nxt       = rem_r;
    slot_nxt      = slot_r;
    step_nxt      = step_r;
    round_nxt     = round_r;
    rank_nxt      = rank_r;
    res_owner_nxt = res_owner_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r;
    out_owner_nxt = out_owner_r;
    out_error_nxt = out_error_r;

    // Drop the result word once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_owner_nxt = '0;
          res_err_nxt   = 1'b0;
          if (in_ch.req_type == ReqSetWeight) begin
            res_err_nxt = !wr_en;
            state_nxt   = ST_DONE;
          end else begin
            slot_nxt  = in_ch.slot;
            cnt_nxt   = '0;
            acc_nxt   = '0;
            state_nxt = ST_SUM;
          end
        end
      end

      ST_SUM: begin
        // Total the weights of the servers in use
        if (cnt_r == n_active) begin
          total_nxt = acc_r;
          rem_nxt   = '0;
          step_nxt  = '0;
          if (acc_r == '0) begin
            res_err_nxt = 1'b1;
            state_nxt   = ST_DONE;
          end else begin
            state_nxt = ST_DIV;
          end
        end else begin
          acc_nxt = acc_plus_w[SumW-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_DIV: begin
        // One remainder bit per cycle
        if (rem_sh >= {1'b0, total_r}) begin
          rem_nxt = rem_diff[SumW-1:0];
        end else begin
          rem_nxt = rem_sh[SumW-1:0];
        end
        slot_nxt = {slot_r[SlotW-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == StepW'(SlotW - 1)) begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          rank_nxt  = '0;
          round_nxt = '0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Walk the sequence until position rem_r is reached or the sequence ends
        if (spread_mode_r == ModeGrouped) begin
          if (cnt_r == n_active) begin
            res_owner_nxt = '0;
            state_nxt     = ST_DONE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
            if (cur_w != '0) begin
              if ({1'b0, rem_r} < acc_plus_w) begin
                res_owner_nxt = rank_r;
                state_nxt     = ST_DONE;
              end else begin
                acc_nxt  = acc_plus_w[SumW-1:0];
                rank_nxt = rank_r + 1'b1;
              end
            end
          end
        end else begin
          if (cur_w > round_r && acc_r == rem_r) begin
            res_owner_nxt = cnt_r[SelW-1:0];
            state_nxt     = ST_DONE;
          end else begin
            if (cur_w > round_r) begin
              acc_nxt = acc_r + 1'b1;
            end
            if (cnt_r + 1'b1 >= n_active) begin
              cnt_nxt   = '0;
              round_nxt = round_r + 1'b1;
              if (round_r == LastRound) begin
                res_owner_nxt = '0;
                state_nxt     = ST_DONE;
              end
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
      end

      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_owner_nxt = res_owner_r;
          out_error_nxt = res_err_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    acc_r       <= acc_nxt;
    total_r     <= total_nxt;
    rem_r       <= rem_nxt;
    slot_r      <= slot_nxt;
    step_r      <= step_nxt;
    round_r     <= round_nxt;
    rank_r      <= rank_nxt;
    res_owner_r <= res_owner_nxt;
    res_err_r   <= res_err_nxt;
    out_owner_r <= out_owner_nxt;
    out_error_r <= out_error_nxt;
  end

  // Weight store, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MaxServers; i++) begin
        weights_r[i] <= '0;
      end
    end else if (wr_en) begin
      weights_r[in_ch.server_sel] <= in_ch.new_weight;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spread_mode_r    <= ModeInterleaved;
      servers_in_use_r <= CntW'(MaxServers);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CfgSpreadMode:   spread_mode_r    <= cfg_ch.data[0];
        CfgServersInUse: servers_in_use_r <= cfg_ch.data[CntW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ dv/weighted_spread_table_tb.sv @@
// Self-checking testbench for the weighted spread table: weight writes and slot lookups.
`timescale 1ns / 100ps

module weighted_spread_table_tb;
  import wst_pkg::*;

  localparam int MaxTotalWeight = 256;
  localparam int ItemTarget     = 850;
  localparam int PhaseBody      = 60;
  localparam int HoldCycles     = 600;
  localparam int DrainCycles    = 300;
  localparam logic [CfgIdxW-1:0] CfgUnmappedLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgUnmappedHi = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [SelW-1:0]   sel;
    logic [WgtW-1:0]   weight;
    logic [SlotW-1:0]  slot;
  } request_t;

  typedef struct packed {
    logic [SelW-1:0]  owner;
    logic             error;
  } owner_result_t;

  logic clk = 1'b0;
  logic rst_n;

  wst_in_if  in_ch ();
  wst_out_if out_ch ();
  wst_cfg_if cfg_ch ();

  weighted_spread_table u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: weight store mirror and register copies
  logic [WgtW-1:0]     weight_mirror [MaxServers];
  logic                mode_cfg;
  logic [CfgDataW-1:0] servers_cfg;

  request_t      pending_reqs[$];
  owner_result_t pending_results[$];

  int  mismatches = 0;
  int  words_sent = 0;
  int  lookups_sent = 0;
  int  results_checked = 0;
  int  error_results = 0;
  int  cfg_writes = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  bit  steady = 1'b0;
  bit  start_hold = 1'b0;
  logic hold_rx = 1'b0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_weight();
    if ($urandom_range(0, 4) == 0) return 0;
    return $urandom_range(1, 15);
  endfunction

  // Servers scanned, saturated at the store depth
  function automatic int active_count();
    return (servers_cfg > MaxServers) ? MaxServers : int'(servers_cfg);
  endfunction

  // Apply one request to the mirror and compute the owner word it produces
  function automatic owner_result_t resolve_request(input request_t rq);
    owner_result_t res;
    int n, total, p, acc, rank, cnt, i, r;
    bit found;
    res = '0;
    n = active_count();
    found = 1'b0;
    if (rq.req_type == ReqSetWeight) begin
      if (int'(rq.sel) < n) weight_mirror[rq.sel] = rq.weight;
      else res.error = 1'b1;
    end else begin
      total = 0;
      for (i = 0; i < n; i++) total += weight_mirror[i];
      if (total > MaxTotalWeight) total = MaxTotalWeight;
      if (total == 0) begin
        res.error = 1'b1;
      end else begin
        p = int'(rq.slot) % total;
        if (mode_cfg == ModeInterleaved) begin
          // Round r lists every server heavier than r, in index order
          cnt = 0;
          for (r = 0; r <= int'(LastRound); r++) begin
            for (i = 0; i < n; i++) begin
              if (!found && int'(weight_mirror[i]) > r) begin
                if (cnt == p) begin
                  res.owner = SelW'(i);
                  found = 1'b1;
                end
                cnt++;
              end
            end
          end
        end else begin
          // Runs of weight entries, named by rank among nonzero servers
          acc = 0;
          rank = 0;
          for (i = 0; i < n; i++) begin
            if (!found && weight_mirror[i] != 0) begin
              if (p < acc + int'(weight_mirror[i])) begin
                res.owner = SelW'(rank);
                found = 1'b1;
              end
              acc += weight_mirror[i];
              rank++;
            end
          end
        end
      end
    end
    return res;
  endfunction

  // Request driver: present the oldest pending word, hold it until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (pending_reqs[0].req_type == ReqLookup) lookups_sent++;
        pending_results.push_back(resolve_request(pending_reqs.pop_front()));
        words_sent++;
        if (!steady) tx_gap = pick_gap();
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_ch.valid      <= 1'b1;
          in_ch.req_type   <= pending_reqs[0].req_type;
          in_ch.server_sel <= pending_reqs[0].sel;
          in_ch.new_weight <= pending_reqs[0].weight;
          in_ch.slot       <= pending_reqs[0].slot;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each taken word against the oldest expectation
  always @(posedge clk) begin
    owner_result_t exp_res;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result word with nothing expected (owner %0d error %0b)",
                                  out_ch.owner, out_ch.error));
        end else begin
          exp_res = pending_results.pop_front();
          results_checked++;
          if (out_ch.error === 1'b1) error_results++;
          if (out_ch.owner !== exp_res.owner)
            flag_mismatch($sformatf("owner %0d, expected %0d", out_ch.owner, exp_res.owner));
          if (out_ch.error !== exp_res.error)
            flag_mismatch($sformatf("error %0b, expected %0b", out_ch.error, exp_res.error));
        end
      end
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady) rx_gap = pick_gap();
      end
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (start_hold);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Run limit
  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  // Wait until every request is taken and every result has come back
  task automatic settle_idle();
    while (pending_reqs.size() != 0 || pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write, only with the block idle
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    settle_idle();
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CfgSpreadMode:   mode_cfg = val[0];
      CfgServersInUse: servers_cfg = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  int counted = 0;

  task automatic add_write(input logic [SelW-1:0] sel, input logic [WgtW-1:0] wgt);
    request_t rq;
    rq.req_type = ReqSetWeight;
    rq.sel      = sel;
    rq.weight   = wgt;
    rq.slot     = SlotW'($urandom_range(0, 255));
    counted++;
    pending_reqs.push_back(rq);
  endtask

  task automatic add_lookup(input logic [SlotW-1:0] slot);
    request_t rq;
    rq.req_type = ReqLookup;
    rq.sel      = SelW'($urandom_range(0, 15));
    rq.weight   = WgtW'($urandom_range(0, 15));
    rq.slot     = slot;
    counted++;
    pending_reqs.push_back(rq);
  endtask

  initial begin
    int i, k, pick, srv, eff, phase;
    bit clear;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = ReqSetWeight;
    in_ch.server_sel = '0;
    in_ch.new_weight = '0;
    in_ch.slot       = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CfgSpreadMode;
    cfg_ch.data      = '0;
    for (i = 0; i < MaxServers; i++) weight_mirror[i] = '0;
    mode_cfg    = ModeInterleaved;
    servers_cfg = CfgDataW'(MaxServers);
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, extreme weights and slots, interleaved mode
    add_lookup(8'd0);
    add_lookup(8'd255);
    add_write(4'd0, 4'd15);
    add_write(4'd15, 4'd15);
    add_write(4'd7, 4'd1);
    add_lookup(8'd0);
    add_lookup(8'd15);
    add_lookup(8'd16);
    add_lookup(8'd30);
    add_lookup(8'd255);

    // Grouped mode, then drop a server to weight zero
    cfg_write(CfgSpreadMode, 5'b11110);
    add_lookup(8'd0);
    add_lookup(8'd29);
    add_lookup(8'd255);
    add_write(4'd7, 4'd0);
    add_lookup(8'd16);

    // Few servers in use: write outside them is refused
    cfg_write(CfgServersInUse, 5'd4);
    add_write(4'd15, 4'd9);
    add_lookup(8'd20);

    // No servers in use: zero total and every write refused
    cfg_write(CfgServersInUse, 5'd0);
    add_lookup(8'd5);
    add_write(4'd0, 4'd3);

    // Oversized count saturates to the full store
    cfg_write(CfgServersInUse, 5'd31);
    add_write(4'd15, 4'd2);
    add_lookup(8'd255);

    // Unmapped register index is ignored
    cfg_write(CfgUnmappedHi, 5'd31);
    cfg_write(CfgSpreadMode, 5'd1);
    add_lookup(8'd31);
    cfg_write(CfgServersInUse, 5'd16);

    // Random phases: a fresh setting, often a weight setup, then mixed traffic
    phase = 0;
    while (counted < ItemTarget) begin
      cfg_write(CfgSpreadMode, CfgDataW'($urandom_range(0, 31)));
      pick = $urandom_range(0, 19);
      if (pick == 0) srv = 0;
      else if (pick == 1) srv = $urandom_range(17, 31);
      else if (pick == 2) srv = MaxServers;
      else if (pick == 3) srv = 1;
      else srv = $urandom_range(1, MaxServers);
      cfg_write(CfgServersInUse, CfgDataW'(srv));
      if ($urandom_range(0, 9) == 0)
        cfg_write(CfgIdxW'($urandom_range(CfgUnmappedLo, CfgUnmappedHi)),
                  CfgDataW'($urandom_range(0, 31)));
      eff = active_count();
      steady = (phase != 0) && ($urandom_range(0, 3) == 0);
      clear = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 3) != 0)
        for (i = 0; i < eff; i++) add_write(SelW'(i), clear ? '0 : WgtW'(pick_weight()));
      for (k = 0; k < PhaseBody; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) add_lookup(SlotW'($urandom_range(0, 255)));
        else if (pick < 9 && eff > 0)
          add_write(SelW'($urandom_range(0, eff - 1)), WgtW'(pick_weight()));
        else add_write(SelW'($urandom_range(0, 15)), WgtW'($urandom_range(0, 15)));
      end
      if (phase == 0) start_hold = 1'b1;
      phase++;
    end

    // Drain, then let the block settle
    settle_idle();
    repeat (DrainCycles) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("tb: %0d request words (%0d lookups) over %0d random phases, %0d config writes",
             words_sent, lookups_sent, phase, cfg_writes);
    $display("tb: %0d result words checked, %0d flagged errors, %0d mismatches",
             results_checked, error_results, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/wst_pkg.sv
rtl/wst_if.sv
rtl/weighted_spread_table.sv
dv/weighted_spread_table_tb.sv
